FILE: hw/rtl/bmm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmm_pkg
// Shared types and constants of the banked memory map unit.
// ----------------------------------------------------------------------------
package bmm_pkg;

  // store sizes
  localparam int RAM_DEPTH   = 262144;
  localparam int FLASH_DEPTH = 262144;
  localparam int RAM_AW      = $clog2(RAM_DEPTH);
  localparam int FLASH_AW    = $clog2(FLASH_DEPTH);
  // banked addresses are 15 offset bits plus 3 bank bits
  localparam int MAP_AW      = 18;

  // address map constants
  localparam logic [7:0]  IO_PAGE       = 8'h7F;
  localparam logic [2:0]  BANK_LOW_MASK = 3'b111;
  localparam int          BANK_RAM_BIT  = 3;
  localparam logic [15:0] BANKED_BASE   = 16'h8000;
  localparam logic [3:0]  BANK_MASK     = 4'b1111;
  localparam int          IO_SEL_BIT    = 3;

  // queue sizes
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PW    = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

  // command kinds
  localparam logic [1:0] KIND_SKIP = 2'd0;
  localparam logic [1:0] KIND_MEM  = 2'd1;
  localparam logic [1:0] KIND_BANK = 2'd2;

  typedef struct packed {
    logic        mode;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        wr_en;
    logic        rd_en;
    logic        io_strobe;
    logic        irq_line;
    logic        cpu_reset;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_valid;
    logic [3:0] active_bank;
    logic       in_irq_or_reset;
  } out_item_t;

  // classified command held between front and back
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] address;
    logic [7:0]  data;
    logic        wr;
    logic        rd;
    logic        suspend;
    logic        restore;
    logic        load;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

  typedef struct packed {
    logic               push;
    out_item_t          item;
  } res_push_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bmm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmm_front
// Accepts bus events, classifies them and holds them in a short command queue.
// ----------------------------------------------------------------------------
module bmm_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  output logic                   full,
  input  wire bmm_pkg::in_item_t in_item,
  output bmm_pkg::cmd_head_t     head,
  input  wire logic              head_pop
);
  import bmm_pkg::*;

  cmd_t                cmdq_mem [CMDQ_DEPTH];
  logic [CMDQ_PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_CW-1:0]  count_r, count_nxt;
  logic                do_push, do_pop;
  cmd_t                cls;

  assign full    = (count_r == CMDQ_CW'(CMDQ_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = head_pop && (count_r != '0);

  // classify the event
  always_comb begin
    cls         = '0;
    cls.address = in_item.address;
    cls.data    = in_item.write_data;
    if (in_item.mode) begin
      cls.kind    = KIND_BANK;
      cls.suspend = in_item.irq_line || in_item.cpu_reset;
      cls.restore = in_item.io_strobe && in_item.address[IO_SEL_BIT];
      cls.load    = in_item.io_strobe && !in_item.address[IO_SEL_BIT];
    end else if (in_item.address[15:8] == IO_PAGE) begin
      cls.kind = KIND_SKIP;
    end else begin
      cls.kind = KIND_MEM;
      cls.wr   = in_item.wr_en;
      cls.rd   = in_item.rd_en;
    end
  end

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == CMDQ_PW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == CMDQ_PW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      cmdq_mem[wr_ptr_r] <= cls;
    end
  end

  assign head.valid = (count_r != '0);
  assign head.cmd   = cmdq_mem[rd_ptr_r];

endmodule

`default_nettype wire

FILE: hw/rtl/bmm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmm_back
// Executes commands: bank state, address mapping, RAM and flash stores.
// Two stages: issue (state update, store access) and result formation.
// ----------------------------------------------------------------------------
module bmm_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire bmm_pkg::cmd_head_t          head,
  output logic                             head_pop,
  input  wire logic [bmm_pkg::OUTQ_CW-1:0] outq_count,
  output bmm_pkg::res_push_t               res
);
  import bmm_pkg::*;

  // bank state
  logic [3:0] bank_r, bank_nxt;
  logic [3:0] saved_r, saved_nxt;
  logic       flag_r, flag_nxt;

  // stores
  logic [7:0] ram_mem   [RAM_DEPTH];
  logic [7:0] flash_mem [FLASH_DEPTH];
  logic [7:0] ram_q_r;
  logic [7:0] flash_q_r;

  // second stage
  logic       s2_valid_r;
  logic       s2_rd_r;
  logic       s2_byp_r;
  logic [7:0] s2_data_r;
  logic       s2_ram_r;
  logic       s2_fok_r;
  logic [3:0] s2_bank_r;
  logic       s2_flag_r;

  logic              fire;
  logic              is_mem;
  logic              hi;
  logic [MAP_AW-1:0] map_addr;
  logic [MAP_AW-1:0] flash_off;
  logic              use_ram;
  logic              f_ok;
  logic [7:0]        rd_data;

  // issue only when the result queue has room for this beat and the one in flight
  assign fire = head.valid &&
                ((OUTQ_CW + 1)'(outq_count) + (OUTQ_CW + 1)'(s2_valid_r)
                 < (OUTQ_CW + 1)'(OUTQ_DEPTH));
  assign head_pop = fire;

  // address mapping
  assign is_mem    = (head.cmd.kind == KIND_MEM);
  assign hi        = (head.cmd.address >= BANKED_BASE);
  assign map_addr  = MAP_AW'(head.cmd.address) |
                     (hi ? {bank_r[2:0] & BANK_LOW_MASK, 15'd0} : '0);
  assign flash_off = map_addr - MAP_AW'(BANKED_BASE);
  assign use_ram   = !hi || bank_r[BANK_RAM_BIT];
  assign f_ok      = ((MAP_AW + 1)'(flash_off) < (MAP_AW + 1)'(FLASH_DEPTH));

  // bank event update
  always_comb begin
    bank_nxt  = bank_r;
    saved_nxt = saved_r;
    flag_nxt  = flag_r;
    if (head.cmd.kind == KIND_BANK) begin
      if (head.cmd.suspend && !flag_nxt) begin
        flag_nxt  = 1'b1;
        saved_nxt = bank_nxt;
        bank_nxt  = '0;
      end
      if (flag_nxt && head.cmd.restore) begin
        bank_nxt = saved_nxt;
        flag_nxt = 1'b0;
      end
      if (head.cmd.load) begin
        bank_nxt = head.cmd.data[3:0] & BANK_MASK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r     <= '0;
      saved_r    <= '0;
      flag_r     <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= fire;
      if (fire) begin
        bank_r  <= bank_nxt;
        saved_r <= saved_nxt;
        flag_r  <= flag_nxt;
      end
    end
  end

  // stage-two payload
  always_ff @(posedge clk) begin
    if (fire) begin
      s2_rd_r   <= is_mem && head.cmd.rd;
      s2_byp_r  <= head.cmd.wr;
      s2_data_r <= head.cmd.data;
      s2_ram_r  <= use_ram;
      s2_fok_r  <= f_ok;
      s2_bank_r <= bank_nxt;
      s2_flag_r <= flag_nxt;
    end
  end

  // RAM port
  always_ff @(posedge clk) begin
    if (fire && is_mem && use_ram) begin
      if (head.cmd.wr) begin
        ram_mem[map_addr[RAM_AW-1:0]] <= head.cmd.data;
      end
      ram_q_r <= ram_mem[map_addr[RAM_AW-1:0]];
    end
  end

  // flash port
  always_ff @(posedge clk) begin
    if (fire && is_mem && !use_ram && f_ok) begin
      if (head.cmd.wr) begin
        flash_mem[flash_off[FLASH_AW-1:0]] <= head.cmd.data;
      end
      flash_q_r <= flash_mem[flash_off[FLASH_AW-1:0]];
    end
  end

  // result formation; a write in the same beat is returned directly
  always_comb begin
    priority if (!s2_rd_r) begin
      rd_data = '0;
    end else if (s2_byp_r) begin
      rd_data = (s2_ram_r || s2_fok_r) ? s2_data_r : '0;
    end else if (s2_ram_r) begin
      rd_data = ram_q_r;
    end else if (s2_fok_r) begin
      rd_data = flash_q_r;
    end else begin
      rd_data = '0;
    end
  end

  assign res.push                 = s2_valid_r;
  assign res.item.read_data       = rd_data;
  assign res.item.read_valid      = s2_rd_r;
  assign res.item.active_bank     = s2_bank_r;
  assign res.item.in_irq_or_reset = s2_flag_r;

endmodule

`default_nettype wire

FILE: hw/rtl/bmm_out_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmm_out_fifo
// Result queue; decouples the result consumer from the execute stages.
// ----------------------------------------------------------------------------
module bmm_out_fifo (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire bmm_pkg::res_push_t          res,
  output logic [bmm_pkg::OUTQ_CW-1:0]      count,
  output logic                             empty,
  input  wire logic                        pop,
  output bmm_pkg::out_item_t               out_item
);
  import bmm_pkg::*;

  out_item_t           q_mem [OUTQ_DEPTH];
  logic [OUTQ_PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [OUTQ_PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [OUTQ_CW-1:0]  count_r, count_nxt;
  logic                do_pop;

  // back end only pushes when it holds a credit, so no full check here
  assign empty  = (count_r == '0);
  assign do_pop = pop && !empty;
  assign count  = count_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (res.push) begin
      wr_ptr_nxt = (wr_ptr_r == OUTQ_PW'(OUTQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == OUTQ_PW'(OUTQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({res.push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.push) begin
      q_mem[wr_ptr_r] <= res.item;
    end
  end

  assign out_item = q_mem[rd_ptr_r];

endmodule

`default_nettype wire

FILE: hw/rtl/banked_memory_map_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// banked_memory_map_unit
// Banked RAM/flash map with IO page hole and bank save/restore on irq/reset.
// ----------------------------------------------------------------------------
//  channel   | ports                      | beat
//  ----------+----------------------------+-------------------------------
//  input     | push, full, in_item        | push && !full
//  result    | empty, pop, out_item       | pop && !empty
//
//  One beat per cycle sustained while the result side keeps popping; each
//  beat's result passes the command queue, the issue and store read stage
//  and the result queue before it is visible. Rate is set by the single port
//  of each store, one access per cycle. Reset (rst_n low, synchronous) clears
//  bank state and queues; the stores are not cleared. A stalled result side
//  fills the result queue, then the command queue, and then raises full.
// ----------------------------------------------------------------------------
module banked_memory_map_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire bmm_pkg::in_item_t  in_item,
  output logic                    empty,
  input  wire logic               pop,
  output bmm_pkg::out_item_t      out_item
);
  import bmm_pkg::*;

  cmd_head_t           head;
  logic                head_pop;
  logic [OUTQ_CW-1:0]  outq_count;
  res_push_t           res;

  bmm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .head     (head),
    .head_pop (head_pop)
  );

  bmm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_pop   (head_pop),
    .outq_count (outq_count),
    .res        (res)
  );

  bmm_out_fifo u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (res),
    .count    (outq_count),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

`default_nettype wire
